@@ hdl/gdr_pkg.sv @@
// ----------------------------------------------------------------------------
// gdr_pkg: shared types and constants of the grid DDA column raycaster
// Screen and map geometry, divider widths, sequencer states and wall colours.
// ----------------------------------------------------------------------------
package gdr_pkg;

   localparam int SCREEN_WIDTH  = 1600;
   localparam int SCREEN_HEIGHT = 1200;
   localparam int MAP_DIM       = 32;
   localparam int FRAC_BITS     = 16;

   // shared divider: numerator up to 2^32, denominator up to 22 bits
   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 22;
   localparam int DIV_CNT_W = 6;

   // (column << 17) / 1600 == (column * CAM_RECIP) >> 17, exact for 12-bit columns
   localparam logic [23:0] CAM_RECIP = 24'd10737419;

   localparam logic [31:0] DIST_SAT   = 32'hFFFF_FFFF;
   localparam logic [6:0]  STEP_LIMIT = 7'(2 * MAP_DIM);
   localparam logic [11:0] LH_CAP     = 12'(2 * SCREEN_HEIGHT);
   localparam logic [11:0] HALF_H     = 12'(SCREEN_HEIGHT / 2);
   localparam logic [11:0] LAST_ROW   = 12'(SCREEN_HEIGHT - 1);
   localparam logic [10:0] HEIGHT_K   = 11'(SCREEN_HEIGHT);

   typedef enum logic [2:0] {
      CSR_POS_X   = 3'd0,
      CSR_POS_Y   = 3'd1,
      CSR_DIR_X   = 3'd2,
      CSR_DIR_Y   = 3'd3,
      CSR_PLANE_X = 3'd4,
      CSR_PLANE_Y = 3'd5
   } csr_index_type;

   typedef enum logic [13:0] {
      ST_CLEAR = 14'b00000000000001,
      ST_IDLE  = 14'b00000000000010,
      ST_CAM   = 14'b00000000000100,
      ST_MUL   = 14'b00000000001000,
      ST_RAY   = 14'b00000000010000,
      ST_SETUP = 14'b00000000100000,
      ST_SDX   = 14'b00000001000000,
      ST_SDY   = 14'b00000010000000,
      ST_DDX   = 14'b00000100000000,
      ST_DDY   = 14'b00001000000000,
      ST_STEP  = 14'b00010000000000,
      ST_CHECK = 14'b00100000000000,
      ST_LH    = 14'b01000000000000,
      ST_FIN   = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
   } div_rsp_type;

   // quotient clamped to the distance range; zero divisor saturates
   function automatic logic [31:0] sat_dist(input logic [DIV_NUM_W-1:0] q,
                                            input logic den_zero);
      logic [31:0] r;
      if (den_zero || q[32]) r = DIST_SAT;
      else                   r = q[31:0];
      return r;
   endfunction

   function automatic rgb_type wall_rgb(input logic [3:0] code, input logic y_side);
      rgb_type c;
      case (code)
         4'd1:    c = '{8'd255, 8'd0,   8'd0};
         4'd2:    c = '{8'd0,   8'd255, 8'd0};
         4'd3:    c = '{8'd0,   8'd0,   8'd255};
         4'd4:    c = '{8'd255, 8'd255, 8'd0};
         default: c = '{8'd255, 8'd0,   8'd255};
      endcase
      if (y_side) begin
         c.red   = c.red   >> 1;
         c.green = c.green >> 1;
         c.blue  = c.blue  >> 1;
      end
      return c;
   endfunction

endpackage

@@ hdl/gdr_div.sv @@
// ----------------------------------------------------------------------------
// gdr_div: restoring divider
// Unsigned, one quotient bit per cycle; done pulses with the quotient.
// ----------------------------------------------------------------------------
module gdr_div import gdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = div_req.den;
         quo_in  = div_req.num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

@@ hdl/grid_dda_column_raycaster.sv @@
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster: column raycaster over a 32 x 32 wall map
// Holds the map in block RAM and casts one ray per column by a DDA walk.
// ----------------------------------------------------------------------------
// After reset the block clears the map, one cell a cycle, and takes no
// word on req_ until that pass is over (csr_ writes are taken throughout).
// A cell write (tuser = 0) gives no result, and the block stays ready for
// the next word. A cast (tuser = 1) gets camera x from a reciprocal
// multiply, then runs through one shared divider five times at most (two
// side distances, two delta distances, line height) and walks the map in a
// step state and a check state per cell, as each cell read waits for the
// registered RAM output. One cast is in flight at a time; the finished word
// sits in the rsp_ register while the next request word is taken.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster import gdr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // column[11:0], cell_row[16:12], cell_col[21:17], cell_value[25:22], zero
   input  logic [31:0] req_tdata,
   // kind[0]: 0 writes a map cell, 1 casts a ray
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // draw_start[11:0], draw_end[23:12], red[31:24], green[39:32], blue[47:40],
   // hit_side[48], wall_code[52:49], no_hit[53], zero
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [20:0] csr_data
);

   state_type   state_ff, state_in;
   logic [9:0]  clr_addr_ff, clr_addr_in;
   logic [20:0] pos_x_ff, pos_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff, plane_x_ff, plane_y_ff;

   logic [35:0] cam_prod_ff;
   logic signed [19:0] cam_ff, cam_in;
   logic signed [37:0] prod_x_ff, prod_y_ff;
   logic signed [21:0] rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic [20:0] adx_ff, adx_in, ady_ff, ady_in;
   logic        neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [16:0] fy_ff, fy_in;
   logic [31:0] sdx_ff, sdx_in, sdy_ff, sdy_in, ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic signed [6:0] mx_ff, mx_in, my_ff, my_in;
   logic [6:0]  steps_ff, steps_in;
   logic        side_ff, side_in, hit_ff, hit_in;
   logic [3:0]  code_ff, code_in;
   logic [11:0] lh_ff, lh_in;
   div_req_type div_req_ff, div_req_in;
   div_rsp_type div_rsp;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   // map RAM
   logic [3:0]  map_mem [MAP_DIM*MAP_DIM];
   logic [3:0]  map_rd_ff;
   logic        mem_we;
   logic [9:0]  mem_waddr, mem_raddr;
   logic [3:0]  mem_wdata;

   // combinational helpers
   logic [16:0] fx;
   logic [32:0] sum_x, sum_y;
   logic [5:0]  bound;
   logic signed [22:0] wall_num;
   logic [21:0] anum;
   logic [31:0] lh_numer;
   logic [10:0] lh_half;
   logic [11:0] ds, de;
   rgb_type     rgb;
   logic        accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= 21'd1441792;
         pos_y_ff   <= 21'd786432;
         dir_x_ff   <= -18'sd65536;
         dir_y_ff   <= '0;
         plane_x_ff <= '0;
         plane_y_ff <= 18'sd43254;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_POS_X:   pos_x_ff   <= csr_data;
            CSR_POS_Y:   pos_y_ff   <= csr_data;
            CSR_DIR_X:   dir_x_ff   <= csr_data[17:0];
            CSR_DIR_Y:   dir_y_ff   <= csr_data[17:0];
            CSR_PLANE_X: plane_x_ff <= csr_data[17:0];
            CSR_PLANE_Y: plane_y_ff <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   gdr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   // distance from the camera to the wall boundary that was crossed
   assign bound    = side_ff ? (6'(my_ff[4:0]) + 6'(neg_y_ff))
                             : (6'(mx_ff[4:0]) + 6'(neg_x_ff));
   assign wall_num = $signed({1'b0, bound, 16'b0})
                   - $signed({2'b00, side_ff ? pos_y_ff : pos_x_ff});
   assign anum     = wall_num[22] ? 22'(-wall_num) : wall_num[21:0];
   assign lh_numer = 32'(HEIGHT_K) * 32'(side_ff ? ady_ff : adx_ff);

   // only used in ST_SETUP, where the ray sign is still in rdx_ff
   assign fx    = rdx_ff[21] ? {1'b0, pos_x_ff[15:0]} : 17'h10000 - {1'b0, pos_x_ff[15:0]};
   assign sum_x = {1'b0, sdx_ff} + {1'b0, ddx_ff};
   assign sum_y = {1'b0, sdy_ff} + {1'b0, ddy_ff};

   // stripe span and colour
   assign lh_half = lh_ff[11:1];
   assign ds  = (lh_half >= HALF_H[10:0]) ? 12'd0 : HALF_H - {1'b0, lh_half};
   assign de  = ({1'b0, lh_half} + HALF_H >= 12'(SCREEN_HEIGHT)) ? LAST_ROW
              : {1'b0, lh_half} + HALF_H;
   assign rgb = wall_rgb(code_ff, side_ff);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cam_in       = cam_ff;
      rdx_in       = rdx_ff;
      rdy_in       = rdy_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      fy_in        = fy_ff;
      sdx_in       = sdx_ff;
      sdy_in       = sdy_ff;
      ddx_in       = ddx_ff;
      ddy_in       = ddy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      steps_in     = steps_ff;
      side_in      = side_ff;
      hit_in       = hit_ff;
      code_in      = code_ff;
      lh_in        = lh_ff;
      div_req_in   = '{start: 1'b0, num: div_req_ff.num, den: div_req_ff.den};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = {req_tdata[16:12], req_tdata[21:17]};
      mem_wdata    = req_tdata[25:22];
      mem_raddr    = {mx_ff[4:0], my_ff[4:0]};

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == 10'(MAP_DIM * MAP_DIM - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == 1'b0) begin
                  mem_we = 1'b1;
               end else begin
                  hit_in   = 1'b0;
                  state_in = ST_CAM;
               end
            end
         end
         ST_CAM: begin
            // column product was captured with the request word
            cam_in   = $signed({1'b0, cam_prod_ff[35:17]}) - 20'sd65536;
            state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_RAY;
         ST_RAY: begin
            rdx_in   = 22'(dir_x_ff) + prod_x_ff[37:16];
            rdy_in   = 22'(dir_y_ff) + prod_y_ff[37:16];
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            neg_x_in   = rdx_ff[21];
            neg_y_in   = rdy_ff[21];
            adx_in     = rdx_ff[21] ? 21'(-rdx_ff) : rdx_ff[20:0];
            ady_in     = rdy_ff[21] ? 21'(-rdy_ff) : rdy_ff[20:0];
            fy_in      = rdy_ff[21] ? {1'b0, pos_y_ff[15:0]}
                                    : 17'h10000 - {1'b0, pos_y_ff[15:0]};
            mx_in      = {2'b00, pos_x_ff[20:16]};
            my_in      = {2'b00, pos_y_ff[20:16]};
            div_req_in = '{1'b1, {fx, 16'b0}, {1'b0, adx_in}};
            state_in   = ST_SDX;
         end
         ST_SDX: begin
            if (div_rsp.done) begin
               sdx_in     = sat_dist(div_rsp.quo, adx_ff == '0);
               div_req_in = '{1'b1, {fy_ff, 16'b0}, {1'b0, ady_ff}};
               state_in   = ST_SDY;
            end
         end
         ST_SDY: begin
            if (div_rsp.done) begin
               sdy_in     = sat_dist(div_rsp.quo, ady_ff == '0);
               div_req_in = '{1'b1, 33'h1_0000_0000, {1'b0, adx_ff}};
               state_in   = ST_DDX;
            end
         end
         ST_DDX: begin
            if (div_rsp.done) begin
               ddx_in     = sat_dist(div_rsp.quo, adx_ff == '0);
               div_req_in = '{1'b1, 33'h1_0000_0000, {1'b0, ady_ff}};
               state_in   = ST_DDY;
            end
         end
         ST_DDY: begin
            if (div_rsp.done) begin
               ddy_in   = sat_dist(div_rsp.quo, ady_ff == '0);
               steps_in = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            // tie steps in y
            if (sdx_ff < sdy_ff) begin
               sdx_in  = sum_x[32] ? DIST_SAT : sum_x[31:0];
               mx_in   = neg_x_ff ? mx_ff - 7'sd1 : mx_ff + 7'sd1;
               side_in = 1'b0;
            end else begin
               sdy_in  = sum_y[32] ? DIST_SAT : sum_y[31:0];
               my_in   = neg_y_ff ? my_ff - 7'sd1 : my_ff + 7'sd1;
               side_in = 1'b1;
            end
            steps_in  = steps_ff + 1'b1;
            mem_raddr = {mx_in[4:0], my_in[4:0]};
            if (mx_in[6:5] != 2'b00 || my_in[6:5] != 2'b00) state_in = ST_FIN;
            else                                             state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (map_rd_ff != '0) begin
               hit_in  = 1'b1;
               code_in = map_rd_ff;
               if (anum == '0) begin
                  lh_in    = LH_CAP;
                  state_in = ST_FIN;
               end else begin
                  div_req_in = '{1'b1, {1'b0, lh_numer}, anum};
                  state_in   = ST_LH;
               end
            end else if (steps_ff == STEP_LIMIT) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_LH: begin
            if (div_rsp.done) begin
               lh_in    = (div_rsp.quo > 33'(LH_CAP)) ? LH_CAP : div_rsp.quo[11:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (hit_ff) begin
                  rsp_data_in = {2'b00, 1'b0, code_ff, side_ff,
                                 rgb.blue, rgb.green, rgb.red, de, ds};
               end else begin
                  rsp_data_in = {2'b00, 1'b1, 53'b0};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         div_req_ff   <= '0;
         steps_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff   <= div_req_in;
         steps_ff     <= steps_in;
      end
      cam_prod_ff <= {24'b0, req_tdata[11:0]} * {12'b0, CAM_RECIP};
      cam_ff      <= cam_in;
      prod_x_ff   <= plane_x_ff * cam_ff;
      prod_y_ff   <= plane_y_ff * cam_ff;
      rdx_ff      <= rdx_in;
      rdy_ff      <= rdy_in;
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      fy_ff       <= fy_in;
      sdx_ff      <= sdx_in;
      sdy_ff      <= sdy_in;
      ddx_ff      <= ddx_in;
      ddy_ff      <= ddy_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      side_ff     <= side_in;
      hit_ff      <= hit_in;
      code_ff     <= code_in;
      lh_ff       <= lh_in;
      rsp_data_ff <= rsp_data_in;
   end

   // map RAM, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      map_rd_ff <= map_mem[mem_raddr];
   end

   // a miss word carries nothing but the flag
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[53] |-> rsp_data_ff[52:0] == '0)
      else $error("no_hit word with non-zero fields");

   // a hit stripe never runs upwards
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff[53] |-> rsp_data_ff[11:0] <= rsp_data_ff[23:12])
      else $error("draw_start above draw_end");

   // walk stays within its step bound
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> steps_ff < STEP_LIMIT)
      else $error("DDA walk beyond step bound");

endmodule

@@ test/tb_grid_dda_column_raycaster.sv @@
// ----------------------------------------------------------------------------
// tb_grid_dda_column_raycaster: self-checking bench for the column raycaster
// Writes map cells and casts columns under several camera settings; a
// scoreboard predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_grid_dda_column_raycaster;
   import gdr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       no_hit;
      logic [3:0] wall_code;
      logic       hit_side;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [11:0] draw_end;
      logic [11:0] draw_start;
   } column_span_type;

   localparam logic KIND_CELL = 1'b0;
   localparam logic KIND_CAST = 1'b1;

   // scoreboard: private map, camera and the queue of predicted spans
   class span_scoreboard;
      logic [3:0]  cells [0:1023];
      longint      cam_px, cam_py, cam_dx, cam_dy, cam_lx, cam_ly;
      column_span_type spans [$];
      int          errors;

      function void reset_state();
         foreach (cells[i]) cells[i] = 4'd0;
         cam_px = 1441792; cam_py = 786432;
         cam_dx = -65536; cam_dy = 0; cam_lx = 0; cam_ly = 43254;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [20:0] v);
         case (idx)
            CSR_POS_X:   cam_px = v;
            CSR_POS_Y:   cam_py = v;
            CSR_DIR_X:   cam_dx = longint'($signed(v[17:0]));
            CSR_DIR_Y:   cam_dy = longint'($signed(v[17:0]));
            CSR_PLANE_X: cam_lx = longint'($signed(v[17:0]));
            CSR_PLANE_Y: cam_ly = longint'($signed(v[17:0]));
            default: ;
         endcase
      endfunction

      function longint quot_sat(longint n, longint d);
         longint q;
         if (d == 0) return 64'hFFFF_FFFF;
         q = n / d;
         return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
      endfunction

      // note an accepted request word
      function void note_request(logic kind, logic [31:0] d);
         longint col, cx, rx, ry, mx, my, ax, ay, fx, fy, sdx, sdy, ddx, ddy;
         longint num, lh, ds, de, sx, sy;
         int side, code, steps;
         logic hit;
         column_span_type s;
         if (kind == KIND_CELL) begin
            cells[{d[16:12], d[21:17]}] = d[25:22];
            return;
         end
         col = d[11:0];
         cx = ((col * 2) << 16) / 1600 - 65536;
         rx = cam_dx + ((cam_lx * cx) >>> 16);
         ry = cam_dy + ((cam_ly * cx) >>> 16);
         mx = cam_px >> 16; my = cam_py >> 16;
         ax = rx < 0 ? -rx : rx; ay = ry < 0 ? -ry : ry;
         sx = rx < 0 ? -1 : 1; sy = ry < 0 ? -1 : 1;
         fx = rx < 0 ? cam_px - (mx << 16) : ((mx + 1) << 16) - cam_px;
         fy = ry < 0 ? cam_py - (my << 16) : ((my + 1) << 16) - cam_py;
         sdx = quot_sat(fx << 16, ax); sdy = quot_sat(fy << 16, ay);
         ddx = quot_sat(64'd1 << 32, ax); ddy = quot_sat(64'd1 << 32, ay);
         hit = 0; side = 0; code = 0;
         if (mx < 32 && my < 32) begin
            for (steps = 0; steps < 64; steps++) begin
               if (sdx < sdy) begin
                  sdx = sdx + ddx > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sdx + ddx;
                  mx += sx; side = 0;
               end else begin
                  sdy = sdy + ddy > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sdy + ddy;
                  my += sy; side = 1;
               end
               if (mx < 0 || mx >= 32 || my < 0 || my >= 32) break;
               code = cells[mx * 32 + my];
               if (code != 0) begin
                  hit = 1;
                  break;
               end
            end
         end
         s = '0;
         if (!hit) begin
            s.no_hit = 1'b1;
            spans.push_back(s);
            return;
         end
         if (side == 0) num = ((mx + (sx < 0 ? 1 : 0)) << 16) - cam_px;
         else           num = ((my + (sy < 0 ? 1 : 0)) << 16) - cam_py;
         if (num < 0) num = -num;
         lh = num == 0 ? 2400 : (1200 * (side == 0 ? ax : ay)) / num;
         if (lh > 2400) lh = 2400;
         ds = 600 - lh / 2; if (ds < 0) ds = 0;
         de = lh / 2 + 600; if (de >= 1200) de = 1199;
         s.draw_start = ds[11:0];
         s.draw_end = de[11:0];
         case (code)
            1: begin s.red = 255; s.green = 0;   s.blue = 0;   end
            2: begin s.red = 0;   s.green = 255; s.blue = 0;   end
            3: begin s.red = 0;   s.green = 0;   s.blue = 255; end
            4: begin s.red = 255; s.green = 255; s.blue = 0;   end
            default: begin s.red = 255; s.green = 0; s.blue = 255; end
         endcase
         if (side == 1) begin
            s.red >>= 1; s.green >>= 1; s.blue >>= 1;
         end
         s.hit_side = side[0];
         s.wall_code = code[3:0];
         spans.push_back(s);
      endfunction

      function void check_span(column_span_type got);
         column_span_type w;
         if (spans.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
         end
         w = spans.pop_front();
         if (got.draw_start !== w.draw_start) begin
            $display("%0t: draw_start exp %0d got %0d", $time, w.draw_start, got.draw_start);
            errors++;
         end
         if (got.draw_end !== w.draw_end) begin
            $display("%0t: draw_end exp %0d got %0d", $time, w.draw_end, got.draw_end);
            errors++;
         end
         if ({got.red, got.green, got.blue} !== {w.red, w.green, w.blue}) begin
            $display("%0t: colour exp %h%h%h got %h%h%h", $time,
                     w.red, w.green, w.blue, got.red, got.green, got.blue);
            errors++;
         end
         if (got.hit_side !== w.hit_side) begin
            $display("%0t: hit_side exp %0d got %0d", $time, w.hit_side, got.hit_side);
            errors++;
         end
         if (got.wall_code !== w.wall_code) begin
            $display("%0t: wall_code exp %0d got %0d", $time, w.wall_code, got.wall_code);
            errors++;
         end
         if (got.no_hit !== w.no_hit) begin
            $display("%0t: no_hit exp %0d got %0d", $time, w.no_hit, got.no_hit);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // column[11:0], cell_row[16:12], cell_col[21:17], cell_value[25:22], zero
   logic [31:0] req_tdata = '0;
   // kind[0]
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // draw_start, draw_end, red, green, blue, hit_side, wall_code, no_hit
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [20:0] csr_data = '0;

   span_scoreboard sb = new();
   bit stim_done = 0;

   grid_dda_column_raycaster dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // requests are noted as the handshake completes
   always @(posedge clock)
      if (!reset && req_tvalid && req_tready) sb.note_request(req_tuser[0], req_tdata);

   // result side: random stalls drawn per word, with calm stretches
   initial begin : rsp_side
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_span(rsp_tdata[53:0]);
      end
   end

   // valid stays up between back-to-back words; dropped only for a gap
   task automatic send_word(logic kind, logic [31:0] d);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_cell(int x, int y, int v);
      send_word(KIND_CELL, {6'd0, 4'(v), 5'(y), 5'(x), 12'd0});
   endtask

   task automatic cast(int c);
      send_word(KIND_CAST, {20'd0, 12'(c)});
   endtask

   task automatic write_reg(csr_index_type idx, logic [20:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   // drain outstanding casts, then let a trailing cell write settle
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (sb.spans.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_camera(logic [20:0] px, logic [20:0] py, logic [17:0] dx,
                             logic [17:0] dy, logic [17:0] lx, logic [17:0] ly);
      write_reg(CSR_POS_X, px);
      write_reg(CSR_POS_Y, py);
      write_reg(CSR_DIR_X, 21'(dx));
      write_reg(CSR_DIR_Y, 21'(dy));
      write_reg(CSR_PLANE_X, 21'(lx));
      write_reg(CSR_PLANE_Y, 21'(ly));
      csr_valid <= 1'b0;
   endtask

   // random room: scattered blocks of all codes, mostly casts
   task automatic random_phase(int n);
      int k;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0)
            write_cell($urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 15));
         else if ($urandom_range(0, 9) == 0) cast($urandom_range(0, 4095));
         else cast($urandom_range(0, 1599));
      end
   endtask

   initial begin : stimulus
      int k;
      sb.reset_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // empty map: every cast misses
      cast(0); cast(1599);
      // walls of every code round the default camera
      for (k = 0; k < 16; k++) write_cell(k, 0, k);
      write_cell(0, 12, 1); write_cell(21, 12, 5); write_cell(31, 31, 15);
      cast(0); cast(800); cast(1599); cast(4095);
      quiesce();
      // wall next to camera on an exact boundary, zero y ray component
      set_camera(21'd1441792, 21'd786432, 18'h3FFFF, 18'd0, 18'd0, 18'd0);
      cast(800); cast(0);
      quiesce();
      set_camera(21'h1FFFFF, 21'h1FFFFF, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000);
      cast(0); cast(4095);
      quiesce();
      // border walls once, then random rooms under several cameras
      for (k = 0; k < 6; k++) begin
         int x;
         if (k == 0) begin
            for (x = 0; x < 32; x++) begin
               write_cell(x, 0, $urandom_range(1, 15));
               write_cell(x, 31, $urandom_range(1, 15));
               write_cell(0, x, $urandom_range(1, 15));
               write_cell(31, x, $urandom_range(1, 15));
            end
         end
         random_phase(75);
         quiesce();
         if (k < 5)
            set_camera(21'($urandom_range(65536, 31 * 65536 - 1)),
                       21'($urandom_range(65536, 31 * 65536 - 1)),
                       18'($urandom_range(0, 18'h3FFFF)), 18'($urandom_range(0, 18'h3FFFF)),
                       18'($urandom_range(0, 18'h3FFFF)), 18'($urandom_range(0, 18'h3FFFF)));
      end
      stim_done = 1;
   end

   initial begin : finisher
      wait (stim_done);
      while (sb.spans.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("tb_grid_dda_column_raycaster: PASS");
      else $display("tb_grid_dda_column_raycaster: FAIL");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("tb_grid_dda_column_raycaster: FAIL");
      $finish;
   end
endmodule
